FILE: rtl/core/msxcart_pkg.sv
// Package for the cartridge mapper with serial link.
// Holds request codes, mapper kinds, port addresses and the control FSM type.
// Used by msxcart_mapper and the top level; depends on nothing.
package msxcart_pkg;

  // Item kinds on the input channel
  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_LINK  = 3'd2,
    REQ_OPEN  = 3'd3,
    REQ_LOAD  = 3'd4,
    REQ_CLOSE = 3'd5,
    REQ_RESET = 3'd6
  } req_t;

  // Mapper kinds of the user ROM
  typedef enum logic [2:0] {
    KIND_PLAIN   = 3'd0,
    KIND_ASCII8  = 3'd1,
    KIND_ASCII16 = 3'd2,
    KIND_KONAMI  = 3'd3,
    KIND_SCC     = 3'd4
  } kind_t;

  // Control FSM
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FILL = 1'b1
  } state_t;

  // Where the read byte of the finishing item comes from
  typedef enum logic [1:0] {
    SRC_REG = 2'd0,
    SRC_RX  = 2'd1,
    SRC_IMG = 2'd2
  } src_t;

  // Commands from the control logic to the bank registers
  typedef struct packed {
    logic  bank_wr;
    logic  load_open;
    kind_t kind;
  } bank_cmd_t;

  // Register addresses in the cartridge window
  localparam logic [15:0] ADDR_GETC    = 16'hBFFC;
  localparam logic [15:0] ADDR_STATUS  = 16'hBFFD;
  localparam logic [15:0] ADDR_PUTC    = 16'hBFFE;
  localparam logic [15:0] ADDR_CONTROL = 16'hBFFF;

  // Cartridge window bounds
  localparam logic [15:0] WIN_LO = 16'h4000;
  localparam logic [15:0] WIN_HI = 16'hC000;

  // Control write bits
  localparam int unsigned CTRL_MODE_BIT   = 2;
  localparam int unsigned CTRL_ENABLE_BIT = 0;

  // Byte returned for unmapped or missing locations
  localparam logic [7:0] BYTE_OPEN = 8'hFF;

  // Width of a mapped image index: 8-bit block times a 16 KB span
  localparam int unsigned IDX_W = 22;
  localparam int unsigned CMP_W = IDX_W + 1;

endpackage

FILE: rtl/core/msxcart_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No reset on contents; read data holds while no read is issued.
// Depends on nothing.
module msxcart_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/msxcart_mapper.sv
// Bank registers and address translation of the user ROM mapper.
// Turns a CPU address into an image index, with mirroring and bank switching.
// Depends on msxcart_pkg.
module msxcart_mapper #(
  parameter int unsigned IMAGE_DEPTH = 131072,
  parameter int unsigned BANK_SLOTS  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  msxcart_pkg::bank_cmd_t             cmd,
  input  logic [15:0]                        address,
  input  logic [7:0]                         data,
  input  logic [$clog2(IMAGE_DEPTH+1)-1:0]   image_length,
  output logic                               rd_hit,
  output logic [$clog2(IMAGE_DEPTH)-1:0]     rd_idx
);

  localparam int unsigned SLOT_W = $clog2(BANK_SLOTS);
  localparam int unsigned IMG_AW = $clog2(IMAGE_DEPTH);

  msxcart_pkg::kind_t mapper_kind;
  logic [7:0]         bank_blocks [BANK_SLOTS];

  logic [15:0]               mir_addr;
  logic                      in_win;
  logic [15:0]               rel;
  logic                      wide_span;
  logic [2:0]                rd_slot;
  logic                      rd_slot_ok;
  logic [7:0]                blk;
  logic [msxcart_pkg::IDX_W-1:0] idx;
  logic [2:0]                wr_slot;
  logic                      wr_ok;
  logic                      wr_slot_ok;

  // Mirror the address for the Konami kinds
  always_comb begin
    mir_addr = address;
    case (mapper_kind)
      msxcart_pkg::KIND_KONAMI: begin
        if (address < msxcart_pkg::WIN_LO) begin
          mir_addr = address + 16'h4000;
        end else if (address >= msxcart_pkg::WIN_HI) begin
          mir_addr = address - 16'h4000;
        end
      end
      msxcart_pkg::KIND_SCC: begin
        if (address < msxcart_pkg::WIN_LO) begin
          mir_addr = address + 16'h8000;
        end else if (address >= msxcart_pkg::WIN_HI) begin
          mir_addr = address - 16'h8000;
        end
      end
      default: mir_addr = address;
    endcase
  end

  // Translate the window offset through the selected bank
  always_comb begin
    in_win     = (mir_addr >= msxcart_pkg::WIN_LO) && (mir_addr < msxcart_pkg::WIN_HI);
    rel        = mir_addr - msxcart_pkg::WIN_LO;
    wide_span  = (mapper_kind == msxcart_pkg::KIND_PLAIN) ||
                 (mapper_kind == msxcart_pkg::KIND_ASCII16);
    rd_slot    = wide_span ? {2'b00, rel[14]} : {1'b0, rel[14:13]};
    rd_slot_ok = {1'b0, rd_slot} < 4'(BANK_SLOTS);
    blk        = bank_blocks[rd_slot[SLOT_W-1:0]];
    idx        = wide_span ? {blk, rel[13:0]} : {1'b0, blk, rel[12:0]};
    rd_hit     = in_win && rd_slot_ok &&
                 (msxcart_pkg::CMP_W'(idx) < msxcart_pkg::CMP_W'(image_length)) &&
                 (msxcart_pkg::CMP_W'(idx) < msxcart_pkg::CMP_W'(IMAGE_DEPTH));
    rd_idx     = idx[IMG_AW-1:0];
  end

  // Decode a bank-switch write
  always_comb begin
    wr_slot = 3'd0;
    wr_ok   = 1'b0;
    if (address >= msxcart_pkg::WIN_LO && address < msxcart_pkg::WIN_HI) begin
      case (mapper_kind)
        msxcart_pkg::KIND_ASCII8: begin
          wr_ok   = (address >= 16'h6000) && (address < 16'h8000);
          wr_slot = {1'b0, address[12:11]};
        end
        msxcart_pkg::KIND_ASCII16: begin
          wr_ok   = (address >= 16'h6000) && (address < 16'h7800) && !address[11];
          wr_slot = {2'b00, address[12]};
        end
        msxcart_pkg::KIND_KONAMI: begin
          wr_ok   = address >= 16'h6000;
          wr_slot = address[15:13] - 3'd2;
        end
        msxcart_pkg::KIND_SCC: begin
          wr_ok   = (address >= 16'h5000) && (address[12:11] == 2'b10);
          wr_slot = address[15:13] - 3'd2;
        end
        default: begin
          wr_ok   = 1'b0;
          wr_slot = 3'd0;
        end
      endcase
    end
    wr_slot_ok = {1'b0, wr_slot} < 4'(BANK_SLOTS);
  end

  // Hold mapper kind and bank registers; load open restores sequential banks
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind <= msxcart_pkg::KIND_PLAIN;
      for (int n = 0; n < BANK_SLOTS; n++) begin
        bank_blocks[n] <= 8'(n);
      end
    end else if (cmd.load_open) begin
      mapper_kind <= cmd.kind;
      for (int n = 0; n < BANK_SLOTS; n++) begin
        bank_blocks[n] <= 8'(n);
      end
    end else if (cmd.bank_wr && wr_ok && wr_slot_ok) begin
      bank_blocks[wr_slot[SLOT_W-1:0]] <= data;
    end
  end

endmodule

FILE: rtl/core/msx_cartridge_mapper_with_serial_port_top.sv
// Top level of the cartridge mapper with serial link: control FSM, receive FIFO
// pointers, image loader and output register. Depends on msxcart_pkg,
// msxcart_ram and msxcart_mapper.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | req_type, address, data, rom_type
//  out     | out_valid / out_ready| read_data, boot_rom_read, boot_rom_index,
//          |                      | tx_valid, tx_byte, dropped
//
// For each item, the accept edge updates state and issues the one synchronous
// read of the FIFO or image RAM; in the FILL state the result, merged with the
// RAM read data, moves into the output register.
// A full output register stalls the FILL state; no new item is taken until it
// drains. Reset clears pointers, counts and flags; RAM contents are not cleared.
module msx_cartridge_mapper_with_serial_port_top #(
  parameter int unsigned RX_DEPTH    = 4096,
  parameter int unsigned IMAGE_DEPTH = 131072,
  parameter int unsigned BANK_SLOTS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic [2:0]  rom_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        boot_rom_read,
  output logic [14:0] boot_rom_index,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        dropped
);

  localparam int unsigned RX_AW  = $clog2(RX_DEPTH);
  localparam int unsigned RX_CW  = $clog2(RX_DEPTH + 1);
  localparam int unsigned IMG_AW = $clog2(IMAGE_DEPTH);
  localparam int unsigned LEN_W  = $clog2(IMAGE_DEPTH + 1);

  msxcart_pkg::state_t state, state_next;
  logic accept;
  logic fill_go;

  // Architectural state
  logic [RX_AW-1:0]  rx_head, rx_head_next;
  logic [RX_AW-1:0]  rx_tail, rx_tail_next;
  logic [RX_CW-1:0]  rx_count, rx_count_next;
  logic [LEN_W-1:0]  image_length, image_length_next;
  logic              image_enabled, image_enabled_next;
  logic              image_ready, image_ready_next;

  // Pending result of the item in flight
  msxcart_pkg::src_t pend_src, pend_src_next;
  logic [7:0]        pend_rd, pend_rd_next;
  logic              pend_boot, pend_boot_next;
  logic [14:0]       pend_bidx, pend_bidx_next;
  logic              pend_txv, pend_txv_next;
  logic [7:0]        pend_txb, pend_txb_next;
  logic              pend_drop, pend_drop_next;

  // Memory and mapper controls
  logic                   rx_we, rx_re;
  logic [7:0]             rx_rdata;
  logic                   img_we, img_re;
  logic [7:0]             img_rdata;
  logic                   map_hit;
  logic [IMG_AW-1:0]      map_idx;
  msxcart_pkg::bank_cmd_t bank_cmd;

  msxcart_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (data),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  msxcart_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (image_length[IMG_AW-1:0]),
    .wdata (data),
    .re    (img_re),
    .raddr (map_idx),
    .rdata (img_rdata)
  );

  msxcart_mapper #(
    .IMAGE_DEPTH (IMAGE_DEPTH),
    .BANK_SLOTS  (BANK_SLOTS)
  ) u_mapper (
    .clk          (clk),
    .rst          (rst),
    .cmd          (bank_cmd),
    .address      (address),
    .data         (data),
    .image_length (image_length),
    .rd_hit       (map_hit),
    .rd_idx       (map_idx)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      msxcart_pkg::ST_IDLE: if (in_valid) state_next = msxcart_pkg::ST_FILL;
      msxcart_pkg::ST_FILL: if (!out_valid || out_ready) state_next = msxcart_pkg::ST_IDLE;
      default:              state_next = msxcart_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    fill_go  = 1'b0;
    unique case (state)
      msxcart_pkg::ST_IDLE: in_ready = 1'b1;
      msxcart_pkg::ST_FILL: fill_go  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        fill_go  = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Execute an accepted item: update state, issue memory access, form result
  always_comb begin
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    rx_count_next      = rx_count;
    image_length_next  = image_length;
    image_enabled_next = image_enabled;
    image_ready_next   = image_ready;
    pend_src_next      = msxcart_pkg::SRC_REG;
    pend_rd_next       = 8'h00;
    pend_boot_next     = 1'b0;
    pend_bidx_next     = 15'd0;
    pend_txv_next      = 1'b0;
    pend_txb_next      = 8'h00;
    pend_drop_next     = 1'b0;
    rx_we              = 1'b0;
    rx_re              = 1'b0;
    img_we             = 1'b0;
    img_re             = 1'b0;
    bank_cmd.bank_wr   = 1'b0;
    bank_cmd.load_open = 1'b0;
    bank_cmd.kind      = (rom_type <= 3'(msxcart_pkg::KIND_SCC)) ?
                         msxcart_pkg::kind_t'(rom_type) : msxcart_pkg::KIND_PLAIN;
    if (accept) begin
      case (req_type)
        msxcart_pkg::REQ_READ: begin
          if (image_enabled) begin
            if (map_hit) begin
              img_re        = 1'b1;
              pend_src_next = msxcart_pkg::SRC_IMG;
            end else begin
              pend_rd_next  = msxcart_pkg::BYTE_OPEN;
            end
          end else if (address == msxcart_pkg::ADDR_GETC) begin
            // Pop the oldest byte; an empty FIFO returns zero
            if (rx_count != '0) begin
              rx_re         = 1'b1;
              pend_src_next = msxcart_pkg::SRC_RX;
              rx_head_next  = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
              rx_count_next = rx_count - 1'b1;
            end
          end else if (address == msxcart_pkg::ADDR_STATUS) begin
            pend_rd_next = {rx_count != '0, image_ready, 6'b000000};
          end else if (address < msxcart_pkg::WIN_LO || address >= msxcart_pkg::WIN_HI) begin
            pend_rd_next = msxcart_pkg::BYTE_OPEN;
          end else begin
            pend_boot_next = 1'b1;
            pend_bidx_next = 15'(address - msxcart_pkg::WIN_LO);
          end
        end
        msxcart_pkg::REQ_WRITE: begin
          if (address == msxcart_pkg::ADDR_PUTC) begin
            pend_txv_next = 1'b1;
            pend_txb_next = data;
          end else if (address == msxcart_pkg::ADDR_CONTROL) begin
            if (data[msxcart_pkg::CTRL_MODE_BIT]) begin
              image_enabled_next = data[msxcart_pkg::CTRL_ENABLE_BIT];
            end
          end else begin
            bank_cmd.bank_wr = 1'b1;
          end
        end
        msxcart_pkg::REQ_LINK: begin
          // Push a link byte, or drop it when the FIFO is full
          if (rx_count == RX_CW'(RX_DEPTH)) begin
            pend_drop_next = 1'b1;
          end else begin
            rx_we         = 1'b1;
            rx_tail_next  = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
            rx_count_next = rx_count + 1'b1;
          end
        end
        msxcart_pkg::REQ_OPEN: begin
          image_ready_next   = 1'b0;
          image_length_next  = '0;
          bank_cmd.load_open = 1'b1;
        end
        msxcart_pkg::REQ_LOAD: begin
          if (image_length == LEN_W'(IMAGE_DEPTH)) begin
            pend_drop_next = 1'b1;
          end else begin
            img_we            = 1'b1;
            image_length_next = image_length + 1'b1;
          end
        end
        msxcart_pkg::REQ_CLOSE: begin
          if (image_length != '0) begin
            image_ready_next = 1'b1;
          end
        end
        msxcart_pkg::REQ_RESET: begin
          image_enabled_next = 1'b0;
        end
        default: begin
          pend_src_next = msxcart_pkg::SRC_REG;
        end
      endcase
    end
  end

  // Control and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= msxcart_pkg::ST_IDLE;
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_count      <= '0;
      image_length  <= '0;
      image_enabled <= 1'b0;
      image_ready   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      rx_count      <= rx_count_next;
      image_length  <= image_length_next;
      image_enabled <= image_enabled_next;
      image_ready   <= image_ready_next;
      if (fill_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the pending result at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_src  <= pend_src_next;
      pend_rd   <= pend_rd_next;
      pend_boot <= pend_boot_next;
      pend_bidx <= pend_bidx_next;
      pend_txv  <= pend_txv_next;
      pend_txb  <= pend_txb_next;
      pend_drop <= pend_drop_next;
    end
  end

  // Load the output register, merging the RAM read data
  always_ff @(posedge clk) begin
    if (fill_go) begin
      case (pend_src)
        msxcart_pkg::SRC_RX:  read_data <= rx_rdata;
        msxcart_pkg::SRC_IMG: read_data <= img_rdata;
        default:              read_data <= pend_rd;
      endcase
      boot_rom_read  <= pend_boot;
      boot_rom_index <= pend_bidx;
      tx_valid       <= pend_txv;
      tx_byte        <= pend_txb;
      dropped        <= pend_drop;
    end
  end

  // FIFO fill never exceeds its depth
  assert property (@(posedge clk) disable iff (rst) rx_count <= RX_CW'(RX_DEPTH))
    else $error("receive FIFO count beyond depth");

  // Empty or full FIFO has equal pointers
  assert property (@(posedge clk) disable iff (rst)
    (rx_count == '0 || rx_count == RX_CW'(RX_DEPTH)) |-> rx_head == rx_tail)
    else $error("receive FIFO pointers disagree with count");

  // Image length stays within the image RAM
  assert property (@(posedge clk) disable iff (rst) image_length <= LEN_W'(IMAGE_DEPTH))
    else $error("image length beyond depth");

  // A ready image is never empty
  assert property (@(posedge clk) disable iff (rst) image_ready |-> image_length != '0)
    else $error("image ready with no bytes loaded");

  // An accepted item blocks the input while it waits in the FILL state
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule
